### sv/bcwh_pkg.sv
`timescale 1ns / 1ps

package bcwh_pkg;

   // default sizing
   localparam int WINDOW_DEPTH_DEF = 64;
   localparam int MAX_TAG_BITS_DEF = 32;

   // field widths
   localparam int PC_W     = 32;
   localparam int CTX_W    = 32;
   localparam int MODE_W   = 3;
   localparam int LEN_W    = 7;
   localparam int STEP_W   = 5;
   localparam int TAG_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // logical window index: skip plus entry number
   localparam int LIDX_W = LEN_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_LEN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TAG_WIDTH   = 3'd4;

   // filter modes
   localparam logic [MODE_W-1:0] FILT_ALL      = 3'd0;
   localparam logic [MODE_W-1:0] FILT_CALL     = 3'd1;
   localparam logic [MODE_W-1:0] FILT_CALL_RET = 3'd2;
   localparam logic [MODE_W-1:0] FILT_UNCOND   = 3'd3;
   localparam logic [MODE_W-1:0] FILT_TAKEN    = 3'd4;

   // register reset values
   localparam logic [MODE_W-1:0] FILTER_MODE_RST = FILT_ALL;
   localparam logic [LEN_W-1:0]  WINDOW_LEN_RST  = 7'd8;
   localparam logic [LEN_W-1:0]  SKIP_LEN_RST    = 7'd8;
   localparam logic [STEP_W-1:0] SHIFT_STEP_RST  = 5'd2;
   localparam logic [TAG_W-1:0]  TAG_WIDTH_RST   = 6'd14;

   // controls from the sequencer to the fold unit
   typedef struct packed {
      logic start;   // clear accumulators and running shift
      logic issue;   // one entry address issued, advance the shift
      logic accum;   // read data present, fold it in
   } fold_ctl_type;

endpackage

### sv/bcwh_window.sv
`timescale 1ns / 1ps

module bcwh_window import bcwh_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  logic [PC_W-1:0]   push_data,
   input  logic [LIDX_W-1:0] cur_idx,
   input  logic [LIDX_W-1:0] pre_idx,
   output logic [PC_W-1:0]   cur_data,
   output logic [PC_W-1:0]   pre_data
);

   localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = ((AW > LIDX_W) ? AW : LIDX_W) + 1;
   localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW_DEPTH - 1);
   localparam logic [FW-1:0]    FULL      = FW'(WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(WINDOW_DEPTH);

   logic [PC_W-1:0] mem [WINDOW_DEPTH];

   // circular buffer: head points at the newest entry
   logic [AW-1:0]    head_ff, head_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0] cur_sum, pre_sum;
   logic             cur_ok, pre_ok;
   logic [AW-1:0]    cur_addr, pre_addr;
   logic             cur_ok_ff, pre_ok_ff;
   logic [PC_W-1:0]  cur_q_ff, pre_q_ff;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (push_en) begin
         head_in = (head_ff == '0) ? LAST_ADDR : head_ff - AW'(1);
         if (fill_ff != FULL) begin
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   // entries never pushed read as zero
   always_comb begin
      cur_ok  = SUM_W'(cur_idx) < SUM_W'(fill_ff);
      pre_ok  = SUM_W'(pre_idx) < SUM_W'(fill_ff);
      cur_sum = SUM_W'(head_ff) + SUM_W'(cur_idx);
      pre_sum = SUM_W'(head_ff) + SUM_W'(pre_idx);
      if (cur_sum >= DEPTH_S) begin
         cur_sum = cur_sum - DEPTH_S;
      end
      if (pre_sum >= DEPTH_S) begin
         pre_sum = pre_sum - DEPTH_S;
      end
      cur_addr = cur_ok ? AW'(cur_sum) : '0;
      pre_addr = pre_ok ? AW'(pre_sum) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         cur_ok_ff <= 1'b0;
         pre_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         cur_ok_ff <= cur_ok;
         pre_ok_ff <= pre_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[head_in] <= push_data;
      end
      cur_q_ff <= mem[cur_addr];
      pre_q_ff <= mem[pre_addr];
   end

   assign cur_data = cur_ok_ff ? cur_q_ff : '0;
   assign pre_data = pre_ok_ff ? pre_q_ff : '0;

endmodule

### sv/bcwh_fold.sv
`timescale 1ns / 1ps

module bcwh_fold import bcwh_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int MAX_TAG_BITS = MAX_TAG_BITS_DEF
) (
   input  logic                             clock,
   input  fold_ctl_type                     ctl,
   input  logic [STEP_W-1:0]                shift_step,
   input  logic [$clog2(MAX_TAG_BITS+1)-1:0] tag_eff,
   input  logic [PC_W-1:0]                  cur_data,
   input  logic [PC_W-1:0]                  pre_data,
   output logic [MAX_TAG_BITS-1:0]          cur_hash,
   output logic [MAX_TAG_BITS-1:0]          pre_hash
);

   // running shift stays below depth times 32
   localparam int SH_W = $clog2(WINDOW_DEPTH * 32) + 1;
   localparam logic [SH_W-1:0] MAX_SH = SH_W'(MAX_TAG_BITS);

   logic [SH_W-1:0]         sh_ff, sh_in, sh_sum, sh_d_ff;
   logic [MAX_TAG_BITS-1:0] acc_cur_ff, acc_pre_ff;
   logic [MAX_TAG_BITS-1:0] cur_shl, pre_shl, mask;

   // advance by the step, wrap by one subtraction of the tag width
   always_comb begin
      sh_sum = sh_ff + SH_W'(shift_step);
      sh_in  = (sh_sum >= SH_W'(tag_eff)) ? sh_sum - SH_W'(tag_eff) : sh_sum;
   end

   // bits shifted past the kept width drop out
   always_comb begin
      if (sh_d_ff >= MAX_SH) begin
         cur_shl = '0;
         pre_shl = '0;
      end else begin
         cur_shl = MAX_TAG_BITS'(cur_data) << sh_d_ff;
         pre_shl = MAX_TAG_BITS'(pre_data) << sh_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         sh_ff      <= '0;
         acc_cur_ff <= '0;
         acc_pre_ff <= '0;
      end else begin
         if (ctl.issue) begin
            sh_ff   <= sh_in;
            sh_d_ff <= sh_ff;
         end
         if (ctl.accum) begin
            acc_cur_ff <= acc_cur_ff ^ cur_shl;
            acc_pre_ff <= acc_pre_ff ^ pre_shl;
         end
      end
   end

   assign mask     = ~({MAX_TAG_BITS{1'b1}} << tag_eff);
   assign cur_hash = acc_cur_ff & mask;
   assign pre_hash = acc_pre_ff & mask;

endmodule

### sv/branch_context_window_hash_top.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// req_       in         req_valid/req_ready    pc, is_call, is_return, is_uncond, taken
// rsp_       out        rsp_valid/rsp_ready    ctx_changed, current_ctx, prefetch_ctx
// csr_       in         csr_wr_en              csr_index, csr_wdata
//
// An admitted branch: the sequencer steps through ISSUE, one entry per hash per cycle from the two
// window read ports, then DRAIN and FINISH, where the result is registered once the output
// is free. Filtered out, empty fold, zero tag width or window_len past the window: idle goes
// straight to FINISH.
// Reset empties the window at once through a fill count; no clearing pass.
// req_ready is high only in idle; the next result holds until the previous one is taken.

module branch_context_window_hash_top import bcwh_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int MAX_TAG_BITS = MAX_TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PC_W-1:0]       req_pc,
   input  logic                  req_is_call,
   input  logic                  req_is_return,
   input  logic                  req_is_uncond,
   input  logic                  req_taken,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ctx_changed,
   output logic [CTX_W-1:0]      rsp_current_ctx,
   output logic [CTX_W-1:0]      rsp_prefetch_ctx,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW_W = $clog2(MAX_TAG_BITS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [MODE_W-1:0] filter_mode_ff;
   logic [LEN_W-1:0]  window_len_ff;
   logic [LEN_W-1:0]  skip_len_ff;
   logic [STEP_W-1:0] shift_step_ff;
   logic [TAG_W-1:0]  tag_width_ff;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              admit_ff, admit_in;
   logic              pend_ff;
   logic              rsp_valid_ff;
   logic              ctx_changed_ff;
   logic [MAX_TAG_BITS-1:0] cur_reg_ff, pre_reg_ff;
   logic [MAX_TAG_BITS-1:0] cur_new, pre_new, fold_cur, fold_pre;

   logic [TW_W-1:0]   tag_eff;
   logic              cur_zero, pre_zero, run;
   logic              accept, admit, out_free, finish;
   logic [LIDX_W-1:0] cur_idx, pre_idx;
   logic [PC_W-1:0]   cur_data, pre_data;
   fold_ctl_type      fctl;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= FILTER_MODE_RST;
         window_len_ff  <= WINDOW_LEN_RST;
         skip_len_ff    <= SKIP_LEN_RST;
         shift_step_ff  <= SHIFT_STEP_RST;
         tag_width_ff   <= TAG_WIDTH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FILTER_MODE: filter_mode_ff <= csr_wdata[MODE_W-1:0];
            REG_WINDOW_LEN:  window_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_SKIP_LEN:    skip_len_ff    <= csr_wdata[LEN_W-1:0];
            REG_SHIFT_STEP:  shift_step_ff  <= csr_wdata[STEP_W-1:0];
            REG_TAG_WIDTH:   tag_width_ff   <= csr_wdata[TAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(tag_width_ff) > MAX_TAG_BITS) begin
         tag_eff = TW_W'(MAX_TAG_BITS);
      end else begin
         tag_eff = TW_W'(tag_width_ff);
      end
      pre_zero = (tag_eff == '0) || (32'(window_len_ff) > WINDOW_DEPTH);
      cur_zero = (tag_eff == '0) ||
                 (32'(window_len_ff) + 32'(skip_len_ff) > WINDOW_DEPTH);
      run      = (window_len_ff != '0) && !pre_zero;
   end

   always_comb begin
      case (filter_mode_ff)
         FILT_ALL:      admit = 1'b1;
         FILT_CALL:     admit = req_is_call;
         FILT_CALL_RET: admit = req_is_call | req_is_return;
         FILT_UNCOND:   admit = req_is_uncond;
         FILT_TAKEN:    admit = req_taken;
         default:       admit = 1'b0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_FINISH) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      admit_in = admit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               admit_in = admit;
               k_in     = '0;
               state_in = (admit && run) ? ST_ISSUE : ST_FINISH;
            end
         end
         ST_ISSUE: begin
            k_in = k_ff + LEN_W'(1);
            if (k_ff == window_len_ff - LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      fctl.start = accept;
      fctl.issue = (state_ff == ST_ISSUE);
      fctl.accum = pend_ff;
   end

   assign pre_idx = LIDX_W'(k_ff);
   assign cur_idx = LIDX_W'(skip_len_ff) + LIDX_W'(k_ff);

   bcwh_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept & admit),
      .push_data (req_pc),
      .cur_idx   (cur_idx),
      .pre_idx   (pre_idx),
      .cur_data  (cur_data),
      .pre_data  (pre_data)
   );

   bcwh_fold #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_TAG_BITS (MAX_TAG_BITS)
   ) u_fold (
      .clock      (clock),
      .ctl        (fctl),
      .shift_step (shift_step_ff),
      .tag_eff    (tag_eff),
      .cur_data   (cur_data),
      .pre_data   (pre_data),
      .cur_hash   (fold_cur),
      .pre_hash   (fold_pre)
   );

   // hold the previous hashes for a filtered-out branch
   always_comb begin
      cur_new = cur_reg_ff;
      pre_new = pre_reg_ff;
      if (admit_ff) begin
         cur_new = cur_zero ? '0 : fold_cur;
         pre_new = pre_zero ? '0 : fold_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         admit_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_reg_ff   <= '0;
         pre_reg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         admit_ff <= admit_in;
         pend_ff  <= (state_ff == ST_ISSUE);
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            cur_reg_ff   <= cur_new;
            pre_reg_ff   <= pre_new;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         ctx_changed_ff <= admit_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ctx_changed  = ctx_changed_ff;
   assign rsp_current_ctx  = CTX_W'(cur_reg_ff);
   assign rsp_prefetch_ctx = CTX_W'(pre_reg_ff);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb import bcwh_pkg::*;;

   localparam int HIST_DEPTH   = WINDOW_DEPTH_DEF;
   localparam int TAG_MAX      = MAX_TAG_BITS_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 140;
   localparam int RANDOM_ITEMS = 1228;

   typedef struct packed {
      logic [PC_W-1:0] pc;
      logic            call;
      logic            ret;
      logic            uncond;
      logic            taken;
   } branch_type;

   typedef struct packed {
      logic             changed;
      logic [CTX_W-1:0] cur;
      logic [CTX_W-1:0] pre;
   } ctx_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_BRANCH, ROW_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      branch_type            br;
      ctx_type               want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PC_W-1:0]       req_pc;
   logic                  req_is_call;
   logic                  req_is_return;
   logic                  req_is_uncond;
   logic                  req_taken;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_ctx_changed;
   logic [CTX_W-1:0]      rsp_current_ctx;
   logic [CTX_W-1:0]      rsp_prefetch_ctx;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic [PC_W-1:0]   pc_history [HIST_DEPTH];
   logic [CTX_W-1:0]  cur_ctx;
   logic [CTX_W-1:0]  pre_ctx;
   logic [MODE_W-1:0] filt_mode;
   logic [LEN_W-1:0]  fold_len;
   logic [LEN_W-1:0]  skip_cnt;
   logic [STEP_W-1:0] shift_inc;
   logic [TAG_W-1:0]  tag_bits;

   ctx_type      pending_ctx [$];
   stim_row_type directed_rows [$];
   ctx_type      got_ctx;
   ctx_type      want_ctx;
   int           error_count;
   int           ctx_checked;
   int           cycle_count;
   int           stall_left;
   bit           idle_on;
   bit           pressure_done;

   branch_context_window_hash_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pc           (req_pc),
      .req_is_call      (req_is_call),
      .req_is_return    (req_is_return),
      .req_is_uncond    (req_is_uncond),
      .req_taken        (req_taken),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ctx_changed  (rsp_ctx_changed),
      .rsp_current_ctx  (rsp_current_ctx),
      .rsp_prefetch_ctx (rsp_prefetch_ctx),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // XOR of count history entries from start, each at a running shift
   function automatic logic [CTX_W-1:0] fold_history(int unsigned start, int unsigned count);
      int unsigned tw;
      int unsigned sh;
      int unsigned k;
      logic [63:0] acc;
      logic [63:0] mask;
      tw = (tag_bits > TAG_MAX) ? TAG_MAX : tag_bits;
      if (tw == 0) return '0;
      if (start + count > HIST_DEPTH) return '0;
      acc = '0;
      sh  = 0;
      for (k = 0; k < count; k++) begin
         if (sh < 64) acc ^= {32'h0, pc_history[start + k]} << sh;
         sh += shift_inc;
         // one subtraction only: the shift may stay at or above the tag width
         if (sh >= tw) sh -= tw;
      end
      mask = (64'd1 << tw) - 64'd1;
      return acc[CTX_W-1:0] & mask[CTX_W-1:0];
   endfunction

   function automatic ctx_type predict_context(branch_type b);
      logic    admit;
      ctx_type r;
      int      k;
      case (filt_mode)
         FILT_ALL:      admit = 1'b1;
         FILT_CALL:     admit = b.call;
         FILT_CALL_RET: admit = b.call | b.ret;
         FILT_UNCOND:   admit = b.uncond;
         FILT_TAKEN:    admit = b.taken;
         default:       admit = 1'b0;
      endcase
      if (admit) begin
         for (k = HIST_DEPTH - 1; k > 0; k--) pc_history[k] = pc_history[k-1];
         pc_history[0] = b.pc;
         cur_ctx = fold_history(skip_cnt, fold_len);
         pre_ctx = fold_history(0, fold_len);
      end
      r.changed = admit;
      r.cur     = cur_ctx;
      r.pre     = pre_ctx;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 15) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.wdata = data;
      return r;
   endfunction

   function automatic stim_row_type branch_row(logic [PC_W-1:0] pc, logic [3:0] fl);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_BRANCH;
      r.br   = {pc, fl};
      return r;
   endfunction

   function automatic stim_row_type known_row(logic [PC_W-1:0] pc, logic [3:0] fl, logic chg,
                                              logic [CTX_W-1:0] cur, logic [CTX_W-1:0] pre);
      stim_row_type r;
      r      = branch_row(pc, fl);
      r.kind = ROW_KNOWN;
      r.want = {chg, cur, pre};
      return r;
   endfunction

   function automatic void add_row(stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // write a register once the block is idle and nothing is outstanding
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_ctx.size() != 0) @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_FILTER_MODE: filt_mode = data[MODE_W-1:0];
         REG_WINDOW_LEN:  fold_len  = data[LEN_W-1:0];
         REG_SKIP_LEN:    skip_cnt  = data[LEN_W-1:0];
         REG_SHIFT_STEP:  shift_inc = data[STEP_W-1:0];
         REG_TAG_WIDTH:   tag_bits  = data[TAG_W-1:0];
         default: ;
      endcase
   endtask

   // offer one request, predict on acceptance
   task automatic send_branch(input branch_type b, input bit known, input ctx_type known_ctx);
      ctx_type p;
      int      gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_pc        = b.pc;
      req_is_call   = b.call;
      req_is_return = b.ret;
      req_is_uncond = b.uncond;
      req_taken     = b.taken;
      do @(posedge clock); while (!req_ready);
      p = predict_context(b);
      pending_ctx.insert(pending_ctx.size(), known ? known_ctx : p);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_ctx.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_ctx = {rsp_ctx_changed, rsp_current_ctx, rsp_prefetch_ctx};
         ctx_checked++;
         if (pending_ctx.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: result with no request outstanding: chg %b cur %h pre %h",
                        $realtime, got_ctx.changed, got_ctx.cur, got_ctx.pre);
         end else begin
            want_ctx = pending_ctx.pop_front();
            if (got_ctx !== want_ctx) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result %0d: chg %b/%b cur %h/%h pre %h/%h (exp/got)",
                           $realtime, ctx_checked, want_ctx.changed, got_ctx.changed,
                           want_ctx.cur, got_ctx.cur, want_ctx.pre, got_ctx.pre);
            end
         end
      end
   end

   // result side: random stalls, plus one long hold-off to back the block up
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!pressure_done && ctx_checked >= 400) begin
            pressure_done = 1'b1;
            rsp_ready     = 1'b0;
            repeat (300) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready  = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      branch_type           b;
      ctx_type              dummy;
      int                   phase;
      int                   sent_here;
      int                   sent_total;
      logic [MODE_W-1:0]    m;
      logic [LEN_W-1:0]     wl;
      logic [LEN_W-1:0]     sk;
      logic [STEP_W-1:0]    st;
      logic [TAG_W-1:0]     tg;
      logic [CSR_IDX_W-1:0] junk_idx;
      int                   r;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pc        = '0;
      req_is_call   = 1'b0;
      req_is_return = 1'b0;
      req_is_uncond = 1'b0;
      req_taken     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      error_count   = 0;
      ctx_checked   = 0;
      cycle_count   = 0;
      stall_left    = 0;
      idle_on       = 1'b1;
      pressure_done = 1'b0;
      dummy         = '0;

      foreach (pc_history[i]) pc_history[i] = '0;
      cur_ctx   = '0;
      pre_ctx   = '0;
      filt_mode = FILTER_MODE_RST;
      fold_len  = WINDOW_LEN_RST;
      skip_cnt  = SKIP_LEN_RST;
      shift_inc = SHIFT_STEP_RST;
      tag_bits  = TAG_WIDTH_RST;

      // reset values: only the newest entry reaches the prefetch hash
      add_row(known_row(32'hFFFF_FFFF, 4'b1111, 1'b1, '0, 32'h3FFF));
      add_row(branch_row(32'h0000_0000, 4'b0000));
      add_row(csr_row(REG_FILTER_MODE, CSR_DATA_W'(FILT_CALL)));
      add_row(branch_row(32'h1234_5678, 4'b0111));
      add_row(branch_row(32'h8000_0000, 4'b1000));
      add_row(csr_row(REG_FILTER_MODE, CSR_DATA_W'(FILT_CALL_RET)));
      add_row(branch_row(32'hDEAD_BEEF, 4'b0100));
      add_row(branch_row(32'h0000_0001, 4'b0011));
      add_row(csr_row(REG_FILTER_MODE, {4'b1010, FILT_UNCOND}));
      add_row(branch_row(32'hCAFE_F00D, 4'b0010));
      add_row(branch_row(32'h7FFF_FFFF, 4'b1101));
      add_row(csr_row(REG_FILTER_MODE, CSR_DATA_W'(FILT_TAKEN)));
      add_row(branch_row(32'hA5A5_A5A5, 4'b0001));
      add_row(branch_row(32'h5A5A_5A5A, 4'b1110));
      // unknown mode admits nothing
      add_row(csr_row(REG_FILTER_MODE, 7'd7));
      add_row(branch_row(32'hFFFF_FFFF, 4'b1111));
      add_row(csr_row(REG_FILTER_MODE, CSR_DATA_W'(FILT_ALL)));
      add_row(csr_row(REG_WINDOW_LEN, 7'd0));
      add_row(known_row(32'h0F0F_0F0F, 4'b0000, 1'b1, '0, '0));
      add_row(csr_row(REG_WINDOW_LEN, 7'd64));
      add_row(csr_row(REG_SKIP_LEN, 7'd0));
      add_row(branch_row(32'hFFFF_0000, 4'b0000));
      // current fold runs one entry past the window
      add_row(csr_row(REG_WINDOW_LEN, 7'd1));
      add_row(csr_row(REG_SKIP_LEN, 7'd64));
      add_row(branch_row(32'h0000_FFFF, 4'b1111));
      add_row(csr_row(REG_TAG_WIDTH, 7'd0));
      add_row(known_row(32'h1357_9BDF, 4'b0000, 1'b1, '0, '0));
      // saturating tag width, full window, widest step
      add_row(csr_row(REG_TAG_WIDTH, 7'd63));
      add_row(csr_row(REG_WINDOW_LEN, 7'd64));
      add_row(csr_row(REG_SKIP_LEN, 7'd0));
      add_row(csr_row(REG_SHIFT_STEP, 7'd31));
      add_row(branch_row(32'hFFFF_FFFF, 4'b0000));
      add_row(branch_row(32'h8000_0001, 4'b0000));
      // running shift climbs past the tag width
      add_row(csr_row(REG_TAG_WIDTH, 7'd1));
      add_row(branch_row(32'h0000_0003, 4'b0000));
      add_row(csr_row(3'd5, 7'h7F));
      add_row(branch_row(32'h2468_ACE0, 4'b0000));
      add_row(csr_row(REG_WINDOW_LEN, 7'd127));
      add_row(csr_row(REG_SKIP_LEN, 7'd127));
      add_row(known_row(32'hFFFF_FFFF, 4'b0000, 1'b1, '0, '0));
      add_row(csr_row(REG_TAG_WIDTH, 7'd32));
      add_row(csr_row(REG_SHIFT_STEP, 7'd0));
      add_row(csr_row(REG_WINDOW_LEN, 7'd2));
      add_row(csr_row(REG_SKIP_LEN, 7'd0));
      add_row(branch_row(32'hAAAA_AAAA, 4'b0000));
      add_row(branch_row(32'h5555_5555, 4'b0000));

      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].idx, directed_rows[i].wdata);
         else
            send_branch(directed_rows[i].br, directed_rows[i].kind == ROW_KNOWN,
                        directed_rows[i].want);
      end

      phase      = 0;
      sent_total = 0;
      while (sent_total < RANDOM_ITEMS) begin
         case (phase)
            0: begin m = FILT_ALL;   wl = 7'd64; sk = 7'd0;  st = 5'd31; tg = 6'd32; end
            1: begin m = FILT_ALL;   wl = 7'd1;  sk = 7'd63; st = 5'd0;  tg = 6'd1;  end
            2: begin m = FILT_TAKEN; wl = 7'd32; sk = 7'd32; st = 5'd17; tg = 6'd63; end
            default: begin
               m = ($urandom_range(0, 9) < 8) ? MODE_W'($urandom_range(0, 4))
                                               : MODE_W'($urandom_range(5, 7));
               r = $urandom_range(0, 9);
               if (r < 7)       wl = LEN_W'($urandom_range(1, 16));
               else if (r == 7) wl = 7'd0;
               else if (r == 8) wl = LEN_W'($urandom_range(17, 64));
               else             wl = LEN_W'($urandom_range(65, 127));
               r = $urandom_range(0, 9);
               if (r < 6)       sk = LEN_W'($urandom_range(0, 16));
               else if (r < 9)  sk = LEN_W'($urandom_range(17, 64));
               else             sk = LEN_W'($urandom_range(65, 127));
               st = STEP_W'($urandom);
               r = $urandom_range(0, 9);
               if (r < 7)       tg = TAG_W'($urandom_range(8, 32));
               else if (r == 7) tg = TAG_W'($urandom_range(0, 7));
               else             tg = TAG_W'($urandom_range(33, 63));
            end
         endcase
         // upper data bits beyond each register are junk and must be dropped
         write_reg(REG_FILTER_MODE, {4'($urandom), m});
         write_reg(REG_WINDOW_LEN, wl);
         write_reg(REG_SKIP_LEN, sk);
         write_reg(REG_SHIFT_STEP, {2'($urandom), st});
         write_reg(REG_TAG_WIDTH, {1'($urandom), tg});
         if ($urandom_range(0, 3) == 0) begin
            junk_idx = CSR_IDX_W'($urandom_range(5, 7));
            write_reg(junk_idx, CSR_DATA_W'($urandom));
         end
         idle_on = (phase % 4) != 3;

         sent_here = 0;
         while (sent_here < 100 && sent_total + sent_here < RANDOM_ITEMS) begin
            r = $urandom_range(0, 15);
            if (r == 0)      b.pc = '0;
            else if (r == 1) b.pc = '1;
            else if (r == 2) b.pc = 32'd1 << $urandom_range(0, 31);
            else             b.pc = $urandom;
            b.call   = $urandom_range(0, 7) < 5;
            b.ret    = $urandom_range(0, 7) < 5;
            b.uncond = $urandom_range(0, 7) < 5;
            b.taken  = $urandom_range(0, 7) < 5;
            send_branch(b, 1'b0, dummy);
            sent_here++;
         end
         sent_total += sent_here;
         phase++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_ctx.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
